[rtl/bxf_pkg.sv]
`timescale 1ns / 1ps

package bxf_pkg;

	// Matrix geometry
	localparam int MAX_SIZE   = 16;
	localparam int MIN_SIZE   = 2;
	localparam int RESET_SIZE = 10;
	localparam int POS_W      = $clog2(MAX_SIZE);
	localparam int SIZE_W     = 5;
	localparam int PIX_W      = 8;

	// Sum widths: one column of three, one column of two, a full 3x3 window
	localparam int COL3_W = PIX_W + 2;
	localparam int COL2_W = PIX_W + 1;
	localparam int SUM_W  = PIX_W + 4;

	// Results caused by one input pixel, at most
	localparam int RES_N  = 4;
	localparam int RES_IW = $clog2(RES_N);

	// Result slots in raster order of the output positions
	localparam int SLOT_UL = 0;
	localparam int SLOT_UR = 1;
	localparam int SLOT_LL = 2;
	localparam int SLOT_LR = 3;

	// Reciprocals for division by 6 and 9 of sums below 2^SUM_W
	localparam int RECIP_W  = 14;
	localparam int RECIP_SH = 16;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((1 << RECIP_SH) + 5) / 6);
	localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << RECIP_SH) + 8) / 9);

	// Number of cells in a neighborhood
	typedef enum logic [1:0] {
		CNT_4,
		CNT_6,
		CNT_9
	} cnt_t;

	// Two older pixels of one column
	typedef struct packed {
		logic [PIX_W-1:0] up1;
		logic [PIX_W-1:0] up2;
	} line_t;

	// Three pixels of one column, top to bottom
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} col_t;

	// Window and position of the newest pixel
	typedef struct packed {
		col_t             col0;
		col_t             col1;
		col_t             col2;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             r_ge1;
		logic             r_ge2;
		logic             c_ge1;
		logic             c_ge2;
		logic             r_last;
		logic             c_last;
	} s1_t;

	// One pending result before division
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		cnt_t             cnt;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last_run;
		logic             last_mat;
	} rslt_t;

	// Truncated mean of a neighborhood sum
	function automatic logic [PIX_W-1:0] mean_of(input logic [SUM_W-1:0] sum, input cnt_t cnt);
		logic [PROD_W-1:0] prod;
		prod = '0;
		mean_of = '0;
		case (cnt)
			CNT_4: mean_of = PIX_W'(sum >> 2);
			CNT_6: begin
				prod = PROD_W'(sum) * PROD_W'(RECIP_6);
				mean_of = prod[RECIP_SH +: PIX_W];
			end
			CNT_9: begin
				prod = PROD_W'(sum) * PROD_W'(RECIP_9);
				mean_of = prod[RECIP_SH +: PIX_W];
			end
			default: mean_of = '0;
		endcase
	endfunction

endpackage

[rtl/bxf_pix_if.sv]
`timescale 1ns / 1ps

interface bxf_pix_if;
	import bxf_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

[rtl/bxf_res_if.sv]
`timescale 1ns / 1ps

interface bxf_res_if;
	import bxf_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] smoothed_value;
	logic [POS_W-1:0] out_row;
	logic [POS_W-1:0] out_column;
	logic             last_of_run;
	logic             last_of_matrix;

	modport source (
		output valid, output smoothed_value, output out_row, output out_column,
		output last_of_run, output last_of_matrix, input ready
	);
	modport sink (
		input valid, input smoothed_value, input out_row, input out_column,
		input last_of_run, input last_of_matrix, output ready
	);
endinterface

[rtl/bxf_front.sv]
`timescale 1ns / 1ps

module bxf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bxf_pkg::SIZE_W-1:0]  cfg_wdata,
	bxf_pix_if.sink                     pix,
	input  logic                        s2_ready,
	output logic                        valid_s1,
	output bxf_pkg::s1_t                item_s1
);
	import bxf_pkg::*;

	logic [POS_W-1:0] lim_q;
	logic [POS_W-1:0] lim_new;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_eff;
	logic [POS_W-1:0] col_eff;
	logic             oob;
	logic             accept;
	line_t            store_q [MAX_SIZE];
	line_t            rd;

	// A transfer is taken when stage one is free or moves on.
	assign pix.ready = !valid_s1 || s2_ready;
	assign accept    = pix.valid && pix.ready;

	// Clamp the written side length and keep the last index.
	always_comb begin
		if (cfg_wdata < SIZE_W'(MIN_SIZE)) begin
			lim_new = POS_W'(MIN_SIZE - 1);
		end else if (cfg_wdata > SIZE_W'(MAX_SIZE)) begin
			lim_new = POS_W'(MAX_SIZE - 1);
		end else begin
			lim_new = POS_W'(cfg_wdata - SIZE_W'(1));
		end
	end

	// A position outside the matrix restarts at the top left corner.
	assign oob     = (row_q > lim_q) || (col_q > lim_q);
	assign row_eff = oob ? '0 : row_q;
	assign col_eff = oob ? '0 : col_q;
	assign rd      = store_q[col_eff];

	// Side length and input position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= POS_W'(RESET_SIZE - 1);
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_we) begin
			lim_q <= lim_new;
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_eff == lim_q) begin
				col_q <= '0;
				row_q <= (row_eff == lim_q) ? '0 : row_eff + POS_W'(1);
			end else begin
				col_q <= col_eff + POS_W'(1);
				row_q <= row_eff;
			end
		end
	end

	// Column store: the two rows above the current one, per column.
	always_ff @(posedge clk) begin
		if (accept) begin
			store_q[col_eff] <= '{up1: pix.pixel_value, up2: rd.up1};
		end
	end

	// Stage one: the 3x3 window shifts by one column on each transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.col2   <= item_s1.col1;
			item_s1.col1   <= item_s1.col0;
			item_s1.col0   <= '{top: rd.up2, mid: rd.up1, bot: pix.pixel_value};
			item_s1.row    <= row_eff;
			item_s1.col    <= col_eff;
			item_s1.r_ge1  <= row_eff >= POS_W'(1);
			item_s1.r_ge2  <= row_eff >= POS_W'(2);
			item_s1.c_ge1  <= col_eff >= POS_W'(1);
			item_s1.c_ge2  <= col_eff >= POS_W'(2);
			item_s1.r_last <= row_eff == lim_q;
			item_s1.c_last <= col_eff == lim_q;
		end
	end

	// Stage one occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s2_ready) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

[rtl/bxf_sums.sv]
`timescale 1ns / 1ps

module bxf_sums (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  bxf_pkg::s1_t    item_s1,
	output logic            s2_ready,
	output logic            nxt_valid,
	output bxf_pkg::rslt_t  nxt,
	input  logic            nxt_ready
);
	import bxf_pkg::*;

	col_t              cols [3];
	logic [COL3_W-1:0] s3 [3];
	logic [COL2_W-1:0] s2 [3];
	logic [SUM_W-1:0]  sum_ul;
	logic [SUM_W-1:0]  sum_ur;
	logic [SUM_W-1:0]  sum_ll;
	logic [SUM_W-1:0]  sum_lr;
	rslt_t             ent_d [RES_N];
	logic [RES_N-1:0]  pend_d;
	rslt_t             ent_s2 [RES_N];
	logic [RES_N-1:0]  pend_s2;
	logic [RES_IW-1:0] sel;
	logic [RES_N-1:0]  rest;
	logic              take;
	logic              load;

	// Column sums; rows above the top and columns left of the edge count as zero.
	always_comb begin
		cols[0] = item_s1.col0;
		cols[1] = item_s1.col1;
		cols[2] = item_s1.col2;
		for (int k = 0; k < 3; k++) begin
			s2[k] = COL2_W'(cols[k].mid) + COL2_W'(cols[k].bot);
			s3[k] = COL3_W'(s2[k]) + COL3_W'(cols[k].top & {PIX_W{item_s1.r_ge2}});
		end
		sum_ul = SUM_W'(s3[0]) + SUM_W'(s3[1]) + (SUM_W'(s3[2]) & {SUM_W{item_s1.c_ge2}});
		sum_ur = SUM_W'(s3[0]) + SUM_W'(s3[1]);
		sum_ll = SUM_W'(s2[0]) + SUM_W'(s2[1]) + (SUM_W'(s2[2]) & {SUM_W{item_s1.c_ge2}});
		sum_lr = SUM_W'(s2[0]) + SUM_W'(s2[1]);
	end

	// The four outputs this pixel can complete, in raster order.
	always_comb begin
		pend_d[SLOT_UL] = item_s1.r_ge1 && item_s1.c_ge1;
		pend_d[SLOT_UR] = item_s1.r_ge1 && item_s1.c_last;
		pend_d[SLOT_LL] = item_s1.r_last && item_s1.c_ge1;
		pend_d[SLOT_LR] = item_s1.r_last && item_s1.c_last;

		ent_d[SLOT_UL].sum      = sum_ul;
		ent_d[SLOT_UL].cnt      = (item_s1.r_ge2 && item_s1.c_ge2) ? CNT_9 :
		                          (item_s1.r_ge2 || item_s1.c_ge2) ? CNT_6 : CNT_4;
		ent_d[SLOT_UL].row      = item_s1.row - POS_W'(1);
		ent_d[SLOT_UL].col      = item_s1.col - POS_W'(1);
		ent_d[SLOT_UL].last_run = 1'b0;
		ent_d[SLOT_UL].last_mat = 1'b0;

		ent_d[SLOT_UR].sum      = sum_ur;
		ent_d[SLOT_UR].cnt      = item_s1.r_ge2 ? CNT_6 : CNT_4;
		ent_d[SLOT_UR].row      = item_s1.row - POS_W'(1);
		ent_d[SLOT_UR].col      = item_s1.col;
		ent_d[SLOT_UR].last_run = 1'b0;
		ent_d[SLOT_UR].last_mat = 1'b0;

		ent_d[SLOT_LL].sum      = sum_ll;
		ent_d[SLOT_LL].cnt      = item_s1.c_ge2 ? CNT_6 : CNT_4;
		ent_d[SLOT_LL].row      = item_s1.row;
		ent_d[SLOT_LL].col      = item_s1.col - POS_W'(1);
		ent_d[SLOT_LL].last_run = 1'b0;
		ent_d[SLOT_LL].last_mat = 1'b0;

		// The bottom right corner closes the matrix.
		ent_d[SLOT_LR].sum      = sum_lr;
		ent_d[SLOT_LR].cnt      = CNT_4;
		ent_d[SLOT_LR].row      = item_s1.row;
		ent_d[SLOT_LR].col      = item_s1.col;
		ent_d[SLOT_LR].last_run = 1'b0;
		ent_d[SLOT_LR].last_mat = 1'b1;
	end

	// Lowest pending slot goes out next.
	always_comb begin
		sel = '0;
		for (int i = RES_N - 1; i >= 0; i--) begin
			if (pend_s2[i]) begin
				sel = RES_IW'(i);
			end
		end
		rest = pend_s2 & ~(RES_N'(1) << sel);
		nxt_valid = |pend_s2;
		nxt = ent_s2[sel];
		nxt.last_run = (rest == '0);
	end

	assign take     = nxt_valid && nxt_ready;
	assign s2_ready = (pend_s2 == '0) || (take && (rest == '0));
	assign load     = valid_s1 && s2_ready;

	// Stage two: pending mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (load) begin
			pend_s2 <= pend_d;
		end else if (take) begin
			pend_s2 <= rest;
		end
	end

	// Stage two: sums, counts and positions.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < RES_N; i++) begin
				ent_s2[i] <= ent_d[i];
			end
		end
	end

endmodule

[rtl/bxf_emit.sv]
`timescale 1ns / 1ps

module bxf_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            nxt_valid,
	input  bxf_pkg::rslt_t  nxt,
	output logic            nxt_ready,
	bxf_res_if.source       res
);
	import bxf_pkg::*;

	logic             out_v_q;
	logic [PIX_W-1:0] mean_q;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic             last_run_q;
	logic             last_mat_q;
	logic             out_free;

	// The output register is free when empty or when its transfer completes.
	assign out_free  = !out_v_q || res.ready;
	assign nxt_ready = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= nxt_valid;
		end
	end

	// Divide by the cell count on the way into the output register.
	always_ff @(posedge clk) begin
		if (out_free && nxt_valid) begin
			mean_q     <= mean_of(nxt.sum, nxt.cnt);
			row_q      <= nxt.row;
			col_q      <= nxt.col;
			last_run_q <= nxt.last_run;
			last_mat_q <= nxt.last_mat;
		end
	end

	assign res.valid          = out_v_q;
	assign res.smoothed_value = mean_q;
	assign res.out_row        = row_q;
	assign res.out_column     = col_q;
	assign res.last_of_run    = last_run_q;
	assign res.last_of_matrix = last_mat_q;

endmodule

[rtl/box_filter_3x3_edge_mean.sv]
`timescale 1ns / 1ps

// Channel   Dir  Payload
// pix       in   pixel_value (8b), raster order
// res       out  smoothed_value (8b), out_row, out_column, last_of_run, last_of_matrix
// cfg       in   cfg_we, cfg_wdata: side length, 2..16 after clamping
//
// One pixel per cycle except during output stalls and bursts; each result is
// registered in stage one, stage two and the output register. Pixels in the last
// column (from row one) or the last row (from column one) complete two to four
// outputs, sent one per cycle while res.ready is high; the input holds meanwhile.
// Reset clears the position and all valid state and sets the side length to 10.
// A stall at the output backs up through stage two and stage one to the input.

module box_filter_3x3_edge_mean (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bxf_pkg::SIZE_W-1:0]  cfg_wdata,
	bxf_pix_if.sink                     pix,
	bxf_res_if.source                   res
);
	import bxf_pkg::*;

	logic  valid_s1;
	s1_t   item_s1;
	logic  s2_ready;
	logic  nxt_valid;
	rslt_t nxt;
	logic  nxt_ready;

	// Position, column store and window register.
	bxf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix       (pix),
		.s2_ready  (s2_ready),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	// Neighborhood sums and the queue of completed outputs.
	bxf_sums u_sums (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.s2_ready  (s2_ready),
		.nxt_valid (nxt_valid),
		.nxt       (nxt),
		.nxt_ready (nxt_ready)
	);

	// Division and output register.
	bxf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.nxt_valid (nxt_valid),
		.nxt       (nxt),
		.nxt_ready (nxt_ready),
		.res       (res)
	);

endmodule

[sim/bxf_mean_checker.sv]
`timescale 1ns / 1ps

module bxf_mean_checker
	import bxf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	bxf_pix_if                pix,
	bxf_res_if                res,
	output int                errors,
	output int                pending,
	output int                checked
);

	// One smoothed output pixel as the result channel carries it.
	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             run_end;
		logic             matrix_end;
	} smooth_t;

	// Predictor state: side length register, three rows of pixels, next position.
	logic [SIZE_W-1:0] side_reg;
	logic [PIX_W-1:0]  rows_q [3][MAX_SIZE];
	int                next_row;
	int                next_col;
	smooth_t           smooth_due [$];

	// Side length after clamping into the supported range.
	function automatic int side_len(input logic [SIZE_W-1:0] s);
		if (s < MIN_SIZE)
			return MIN_SIZE;
		if (s > MAX_SIZE)
			return MAX_SIZE;
		return int'(s);
	endfunction

	// Truncated mean of the in-bounds cells around one output position.
	function automatic smooth_t window_mean(input int r, input int c, input int n);
		int unsigned total;
		int unsigned cells;
		smooth_t     item;
		total = 0;
		cells = 0;
		for (int i = r - 1; i <= r + 1; i++) begin
			for (int j = c - 1; j <= c + 1; j++) begin
				if (i >= 0 && i < n && j >= 0 && j < n) begin
					total += rows_q[i % 3][j];
					cells++;
				end
			end
		end
		item.value      = PIX_W'(total / cells);
		item.row        = POS_W'(r);
		item.col        = POS_W'(c);
		item.run_end    = 1'b0;
		item.matrix_end = (r == n - 1 && c == n - 1);
		return item;
	endfunction

	// Store one pixel and queue every output that it completes, in raster order.
	task automatic predict_pixel(input logic [PIX_W-1:0] px);
		int      n;
		int      r;
		int      c;
		smooth_t burst [$];
		n = side_len(side_reg);
		r = next_row;
		c = next_col;
		if (r >= n || c >= n) begin
			r = 0;
			c = 0;
		end
		rows_q[r % 3][c] = px;
		if (r >= 1 && c >= 1)
			burst.push_back(window_mean(r - 1, c - 1, n));
		if (r >= 1 && c == n - 1)
			burst.push_back(window_mean(r - 1, c, n));
		if (r == n - 1) begin
			if (c >= 1)
				burst.push_back(window_mean(r, c - 1, n));
			if (c == n - 1)
				burst.push_back(window_mean(r, c, n));
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].run_end = 1'b1;
		foreach (burst[k])
			smooth_due.push_back(burst[k]);
		c++;
		if (c >= n) begin
			c = 0;
			r++;
			if (r >= n)
				r = 0;
		end
		next_row = r;
		next_col = c;
	endtask

	// Compare one received output with the oldest prediction.
	task automatic check_output(input smooth_t got);
		smooth_t want;
		if (smooth_due.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%t: unexpected output value %0d at row %0d col %0d",
					$realtime, got.value, got.row, got.col);
			return;
		end
		want = smooth_due.pop_front();
		checked++;
		if (got !== want) begin
			errors++;
			if (errors <= 10) begin
				$display("%t: mismatch: expected value %0d row %0d col %0d run_end %0b matrix_end %0b",
					$realtime, want.value, want.row, want.col, want.run_end, want.matrix_end);
				$display("%t:   got value %0d row %0d col %0d run_end %0b matrix_end %0b",
					$realtime, got.value, got.row, got.col, got.run_end, got.matrix_end);
			end
		end
	endtask

	// Watch the register port and both channels at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_reg = SIZE_W'(RESET_SIZE);
			next_row = 0;
			next_col = 0;
			smooth_due.delete();
			errors   = 0;
			checked  = 0;
		end else begin
			if (cfg_we) begin
				side_reg = cfg_wdata;
				next_row = 0;
				next_col = 0;
			end
			if (res.valid && res.ready)
				check_output({res.smoothed_value, res.out_row, res.out_column,
					res.last_of_run, res.last_of_matrix});
			if (pix.valid && pix.ready)
				predict_pixel(pix.pixel_value);
		end
		pending = smooth_due.size();
	end

endmodule

[sim/tb_box_filter_3x3_edge_mean.sv]
`timescale 1ns / 1ps

module tb_box_filter_3x3_edge_mean;
	import bxf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_GAP   = 8;
	localparam int RANDOM_N    = 500;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	int                errors;
	int                pending;
	int                checked;

	// Stimulus bookkeeping and the controls shared with the receiver.
	int pixels_sent;
	int side_settings;
	int idle_cycles;
	int hold_asks;
	int hold_seen;
	int hold_left;
	bit quiet;

	bxf_pix_if pix_ch ();
	bxf_res_if res_ch ();

	box_filter_3x3_edge_mean i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix       (pix_ch),
		.res       (res_ch)
	);

	bxf_mean_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix       (pix_ch),
		.res       (res_ch),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: random back-pressure, a long hold-off on request, none while quiet.
	initial begin
		res_ch.ready = 1'b0;
		hold_seen    = 0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (quiet) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= 14);
			end
		end
	end

	// Watchdog: end the run when no transfer and no write happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d outputs outstanding",
					idle_cycles, pending);
				$display("tb_box_filter_3x3_edge_mean: FAIL");
				$finish;
			end
		end
	end

	// Offer one pixel, with random gaps unless quiet, until it is accepted.
	task automatic send_pixel(input logic [PIX_W-1:0] px);
		@(negedge clk);
		if (!quiet) begin
			while ($urandom_range(0, 99) < 14) begin
				pix_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.pixel_value <= px;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		pixels_sent++;
	endtask

	// Stop offering and wait until every predicted output has arrived.
	task automatic settle(input int extra);
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// Write the side length once the block has drained.
	task automatic write_side(input logic [SIZE_W-1:0] s);
		settle(DRAIN_GAP);
		cfg_we    <= 1'b1;
		cfg_wdata <= s;
		@(negedge clk);
		cfg_we    <= 1'b0;
		side_settings++;
	endtask

	// Main stimulus: directed corner cases, then random matrices.
	initial begin
		int                size_sel;
		int                eff;
		int                full;
		int                count;
		int                phase;
		int                directed_n;
		logic [PIX_W-1:0]  px;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		pix_ch.valid       = 1'b0;
		pix_ch.pixel_value = '0;
		pixels_sent        = 0;
		side_settings      = 0;
		idle_cycles        = 0;
		hold_asks          = 0;
		quiet              = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Partial matrix at the reset side length; the write below abandons it.
		for (int i = 0; i < 12; i++)
			send_pixel((i % 2) ? 8'hFF : 8'h00);

		// Smallest side, two matrices back to back to cover the wrap.
		write_side(SIZE_W'(2));
		repeat (4) send_pixel(8'hFF);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h01);
		send_pixel(8'hFE);

		// All-maximum 3x3 matrix: corner, edge and inner sums at their largest.
		write_side(SIZE_W'(3));
		repeat (9) send_pixel(8'hFF);
		directed_n = pixels_sent;

		// Random phases: the first few force the largest side and out-of-range values.
		phase = 0;
		while (pixels_sent < directed_n + RANDOM_N) begin
			case (phase)
				0: size_sel = 16;
				1: size_sel = 31;
				2: size_sel = 0;
				3: size_sel = 1;
				4: size_sel = 17;
				default: begin
					count = $urandom_range(0, 19);
					if (count == 0)
						size_sel = $urandom_range(0, 1);
					else if (count < 4)
						size_sel = $urandom_range(7, 12);
					else
						size_sel = $urandom_range(2, 5);
				end
			endcase
			eff  = (size_sel < MIN_SIZE) ? MIN_SIZE : (size_sel > MAX_SIZE) ? MAX_SIZE : size_sel;
			full = eff * eff;
			if (eff >= 12 && phase != 0)
				count = $urandom_range(2 * eff + 2, 3 * eff);
			else if (phase != 0 && $urandom_range(0, 4) == 0)
				count = $urandom_range(1, full - 1);
			else
				count = full * ((eff <= 6) ? $urandom_range(1, 3) : 1);

			write_side(SIZE_W'(size_sel));

			// The full largest matrix runs without gaps while the receiver holds off.
			if (phase == 0) begin
				quiet = 1'b1;
				hold_asks++;
			end
			for (int i = 0; i < count; i++) begin
				if (phase == 3 && i == count / 2)
					settle(0);
				if ($urandom_range(0, 9) == 0)
					px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				else
					px = PIX_W'($urandom_range(0, 255));
				send_pixel(px);
			end
			quiet = 1'b0;
			phase++;
		end

		// Drain, then give the pipeline time to show any stray output.
		settle(16);

		$display("Sent %0d pixels over %0d side-length settings, largest and out-of-range included;",
			pixels_sent, side_settings);
		$display("compared %0d smoothed outputs, %0d mismatches.", checked, errors);
		if (errors == 0 && pending == 0)
			$display("tb_box_filter_3x3_edge_mean: PASS");
		else
			$display("tb_box_filter_3x3_edge_mean: FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/bxf_pkg.sv
rtl/bxf_pix_if.sv
rtl/bxf_res_if.sv
rtl/bxf_front.sv
rtl/bxf_sums.sv
rtl/bxf_emit.sv
rtl/box_filter_3x3_edge_mean.sv
sim/bxf_mean_checker.sv
sim/tb_box_filter_3x3_edge_mean.sv
